/* rtl/core/lpmt_pkg.sv */
// Shared types and constants for the long-press mode toggle command block.
package lpmt_pkg;

  localparam int COUNTER_BITS_DEF = 16;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_VOLUME     = 2'd2,
    REG_TRACK      = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [15:0] LONG_PRESS_RST = 16'd5000;
  localparam logic [4:0]  VOLUME_RST     = 5'd30;
  localparam logic [15:0] TRACK_RST      = 16'd1;

  // mode change caused by one tick
  typedef enum logic [1:0] {
    CHG_NONE   = 2'd0,
    CHG_LIGHT  = 2'd1,
    CHG_MOTION = 2'd2
  } change_t;

  // outcome of one tick, debounce core to sequencer
  typedef struct packed {
    change_t change;
    logic    mode;
    logic    stable;
  } tick_t;

endpackage

/* rtl/core/lpmt_debounce.sv */
// Debounce, press timing and mode decision for one button tick.
module lpmt_debounce #(
  parameter int COUNTER_BITS = lpmt_pkg::COUNTER_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           raw,
  input  logic [15:0]    debounce_ticks,
  input  logic [15:0]    long_press_ticks,
  output lpmt_pkg::tick_t tick
);
  import lpmt_pkg::*;

  localparam int CW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

  logic                    previous_raw;
  logic                    debounced_level;
  logic [COUNTER_BITS-1:0] hold_counter;
  logic [COUNTER_BITS-1:0] press_counter;
  logic                    light_mode;

  logic                    debounced_level_next;
  logic [COUNTER_BITS-1:0] hold_counter_next;
  logic [COUNTER_BITS-1:0] press_counter_next;
  logic                    light_mode_next;
  logic [COUNTER_BITS-1:0] press_inc;
  logic                    level_ok;
  logic                    is_long;
  change_t                 change;

  always_comb begin
    press_inc = press_counter;
    if (debounced_level && (press_counter != '1)) begin
      press_inc = press_counter + 1'b1;
    end

    if (raw != previous_raw) begin
      hold_counter_next = '0;
    end else if (hold_counter != '1) begin
      hold_counter_next = hold_counter + 1'b1;
    end else begin
      hold_counter_next = hold_counter;
    end

    level_ok = (CW'(hold_counter_next) > CW'(debounce_ticks)) && (raw != debounced_level);
    is_long  = CW'(press_inc) >= CW'(long_press_ticks);

    debounced_level_next = debounced_level;
    press_counter_next   = press_inc;
    light_mode_next      = light_mode;
    change               = CHG_NONE;

    if (level_ok) begin
      debounced_level_next = raw;
      if (raw) begin
        press_counter_next = '0;
      end else if (!light_mode && is_long) begin
        light_mode_next = 1'b1;
        change          = CHG_LIGHT;
      end else if (light_mode && !is_long) begin
        light_mode_next = 1'b0;
        change          = CHG_MOTION;
      end
    end

    tick.change = change;
    tick.mode   = light_mode_next;
    tick.stable = debounced_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw    <= 1'b0;
      debounced_level <= 1'b0;
      hold_counter    <= '0;
      press_counter   <= '0;
      light_mode      <= 1'b0;
    end else if (step) begin
      previous_raw    <= raw;
      debounced_level <= debounced_level_next;
      hold_counter    <= hold_counter_next;
      press_counter   <= press_counter_next;
      light_mode      <= light_mode_next;
    end
  end

endmodule

/* rtl/core/long_press_mode_toggle_cmd.sv */
// Top level: button debounce, long-press mode toggle and command frame output.
//
//  channel | signals                                          | moves
//  --------+--------------------------------------------------+---------------------------
//  in      | in_valid, in_ready, button_level                  | one tick sample per request
//  out     | out_valid, out_ready, mode_now, stable_level,     | 1, 5 or 11 results per request
//          | frame_byte, byte_valid, last_of_run               |
//  cfg     | cfg_write, cfg_index, cfg_data                    | one register write per cycle
//
// A tick is decided in the cycle its request is taken; its results then leave
// from a job register through the output register, one per cycle unless the
// output stalls. A plain tick gives 1 result, a return to motion mode 5,
// entering light mode 11; a new tick is taken once the job register is empty
// or its last result moves out. A stalled output holds its result, and the job
// register then takes a tick only if empty. Synchronous reset clears the valid
// flags and debounce state, restores register defaults, and requests are taken
// after it; a result passes the job register, then the output register.
module long_press_mode_toggle_cmd #(
  parameter int COUNTER_BITS = lpmt_pkg::COUNTER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               button_level,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               mode_now,
  output logic                               stable_level,
  output logic [7:0]                         frame_byte,
  output logic                               byte_valid,
  output logic                               last_of_run,
  input  logic                               cfg_write,
  input  logic [lpmt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lpmt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import lpmt_pkg::*;

  // frame layout
  localparam logic [7:0] FRAME_PREFIX = 8'hAA;
  localparam logic [7:0] OP_VOLUME    = 8'h13;
  localparam logic [7:0] LEN_VOLUME   = 8'h01;
  localparam logic [7:0] OP_TRACK     = 8'h07;
  localparam logic [7:0] LEN_TRACK    = 8'h02;
  localparam logic [4:0] VOLUME_MAX   = 5'd30;
  localparam int         IDX_BITS     = 4;
  localparam logic [IDX_BITS-1:0] VOL_LAST = 4'd4;   // volume checksum
  localparam logic [IDX_BITS-1:0] TRK_LAST = 4'd10;  // track checksum

  // config registers
  logic [15:0] debounce_ticks;
  logic [15:0] long_press_ticks;
  logic [4:0]  volume_level;
  logic [15:0] track_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RST;
      long_press_ticks <= LONG_PRESS_RST;
      volume_level     <= VOLUME_RST;
      track_number     <= TRACK_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE:   debounce_ticks   <= cfg_data;
        REG_LONG_PRESS: long_press_ticks <= cfg_data;
        REG_VOLUME:     volume_level     <= cfg_data[4:0];
        REG_TRACK:      track_number     <= cfg_data;
        default:        ;
      endcase
    end
  end

  // tick decision
  tick_t tick;
  logic  accept;

  lpmt_debounce #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_debounce (
    .clk             (clk),
    .rst             (rst),
    .step            (accept),
    .raw             (button_level),
    .debounce_ticks  (debounce_ticks),
    .long_press_ticks(long_press_ticks),
    .tick            (tick)
  );

  // byte at a position of the tick's burst
  function automatic logic [7:0] burst_byte(input change_t chg, input logic [IDX_BITS-1:0] idx,
                                            input logic [4:0] vol, input logic [15:0] trk);
    logic [7:0] v;
    logic [7:0] b;
    v = {3'b000, (vol > VOLUME_MAX) ? VOLUME_MAX : vol};
    b = 8'h00;
    if (chg != CHG_NONE) begin
      case (idx)
        4'd0:    b = FRAME_PREFIX;
        4'd1:    b = OP_VOLUME;
        4'd2:    b = LEN_VOLUME;
        4'd3:    b = v;
        4'd4:    b = FRAME_PREFIX + OP_VOLUME + LEN_VOLUME + v;
        4'd5:    b = FRAME_PREFIX;
        4'd6:    b = OP_TRACK;
        4'd7:    b = LEN_TRACK;
        4'd8:    b = trk[15:8];
        4'd9:    b = trk[7:0];
        4'd10:   b = FRAME_PREFIX + OP_TRACK + LEN_TRACK + trk[15:8] + trk[7:0];
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

  // job register: one tick whose results are still going out
  logic                job_valid;
  change_t             job_change;
  logic                job_mode;
  logic                job_stable;
  logic [IDX_BITS-1:0] job_idx;
  logic                job_last;
  logic                move;

  always_comb begin
    unique case (job_change)
      CHG_NONE:   job_last = 1'b1;
      CHG_MOTION: job_last = (job_idx == VOL_LAST);
      CHG_LIGHT:  job_last = (job_idx == TRK_LAST);
      default:    job_last = 1'b1;
    endcase
  end

  assign move     = job_valid && (!out_valid || out_ready);
  assign in_ready = !job_valid || (move && job_last);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept) begin
      job_valid <= 1'b1;
    end else if (move && job_last) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_change <= tick.change;
      job_mode   <= tick.mode;
      job_stable <= tick.stable;
      job_idx    <= '0;
    end else if (move) begin
      job_idx    <= job_idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      mode_now     <= job_mode;
      stable_level <= job_stable;
      frame_byte   <= burst_byte(job_change, job_idx, volume_level, track_number);
      byte_valid   <= (job_change != CHG_NONE);
      last_of_run  <= job_last;
    end
  end

endmodule

/* rtl/core/lpmt_checker.sv */
// Port-level checks for the long-press mode toggle block, with bind.
module lpmt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       mode_now,
  input logic       stable_level,
  input logic [7:0] frame_byte,
  input logic       byte_valid,
  input logic       last_of_run
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(last_of_run))
    else $error("stalled result changed");

  // a status result stands alone and carries no byte
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last_of_run && (frame_byte == 8'h00))
    else $error("bad status result");

  // mode and level stay fixed inside one burst
  a_burst_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |=> $stable(mode_now) && $stable(stable_level))
    else $error("mode changed inside a burst");

  // no result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind long_press_mode_toggle_cmd lpmt_checker u_lpmt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .mode_now    (mode_now),
  .stable_level(stable_level),
  .frame_byte  (frame_byte),
  .byte_valid  (byte_valid),
  .last_of_run (last_of_run)
);

/* verif/tb_long_press_mode_toggle_cmd.sv */
// Self-checking testbench for the long-press mode toggle command block.
`timescale 1ns / 1ps

module tb_long_press_mode_toggle_cmd;
  import lpmt_pkg::*;

  // Command frame bytes
  localparam logic [7:0] FRAME_HEAD = 8'hAA;
  localparam logic [7:0] OP_VOLUME  = 8'h13;
  localparam logic [7:0] LEN_VOLUME = 8'h01;
  localparam logic [7:0] OP_TRACK   = 8'h07;
  localparam logic [7:0] LEN_TRACK  = 8'h02;
  localparam logic [7:0] VOLUME_CAP = 8'd30;

  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_TICKS   = 45;

  // One result of a tick as seen on the output channel
  typedef struct packed {
    logic       mode;
    logic       stable;
    logic [7:0] data;
    logic       carried;
    logic       last;
  } result_t;

  // Directed plan: a row is either a tick request or a register write.
  // Typed rows carry their status result inline; the rest go to the predictor.
  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_reg_t    sel;
    logic [15:0] value;
    logic        lvl;
    logic        typed;
    logic        mode;
    logic        stable;
  } plan_row_t;

  localparam int PLAN_ROWS = 31;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // defaults after reset: debounce of 50 never reached, nothing moves
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b0, 1'b1, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b0, 1'b1, 1'b0, 1'b0},
    // zero debounce, zero long-press count (every press long),
    // volume 31 with junk upper bits (sent as 30), track all ones
    '{ROW_WRITE, REG_DEBOUNCE,   16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_LONG_PRESS, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_VOLUME,     16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_TRACK,      16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0},
    // press: first high sample only restarts the hold count
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b1, 1'b1, 1'b0, 1'b1},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b0, 1'b1, 1'b0, 1'b1},
    // release accepted: enter light mode, volume + track frames
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    // long press while in light mode: no change
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    // largest long-press count, volume and track zero
    '{ROW_WRITE, REG_LONG_PRESS, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_VOLUME,     16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_TRACK,      16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    // short press in light mode: back to motion, volume frame only
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    // short press in motion mode: no change
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    // bouncing contact: level never holds, stays low and in motion mode
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b0, 1'b1, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_TICK,  REG_DEBOUNCE,   16'h0000, 1'b0, 1'b1, 1'b0, 1'b0}
  };

  // Block inputs, known from time zero
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        button_level = 1'b0;
  logic        out_ready    = 1'b0;
  logic        cfg_write    = 1'b0;
  cfg_reg_t    cfg_index    = REG_DEBOUNCE;
  logic [15:0] cfg_data     = 16'h0000;

  // Block outputs
  logic       in_ready;
  logic       out_valid;
  logic       mode_now;
  logic       stable_level;
  logic [7:0] frame_byte;
  logic       byte_valid;
  logic       last_of_run;

  // Register shadow
  logic [15:0] cfg_debounce   = DEBOUNCE_RST;
  logic [15:0] cfg_long_press = LONG_PRESS_RST;
  logic [4:0]  cfg_volume     = VOLUME_RST;
  logic [15:0] cfg_track      = TRACK_RST;

  // Predicted debounce / mode state
  logic        raw_prev     = 1'b0;
  logic        level_stable = 1'b0;
  logic [15:0] hold_cnt     = '0;
  logic [15:0] press_cnt    = '0;
  logic        in_light     = 1'b0;

  result_t results_due[$];
  int      mismatches = 0;
  int      sent_ticks = 0;
  int      stall_left = 0;
  bit      quiet      = 1'b0;

  long_press_mode_toggle_cmd DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .button_level (button_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mode_now     (mode_now),
    .stable_level (stable_level),
    .frame_byte   (frame_byte),
    .byte_valid   (byte_valid),
    .last_of_run  (last_of_run),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("long_press_mode_toggle_cmd verification failed");
    $finish;
  end

  // Idle length: mostly none, some short, a few long; none in quiet stretches
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Expected bytes of one command frame plus its checksum byte
  function automatic void queue_frame(input logic [39:0] bytes, input int n,
                                      input logic closes);
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    sum = 8'h00;
    for (i = 0; i < n; i++) begin
      b = bytes[8*(n-1-i) +: 8];
      sum += b;
      results_due.push_back(result_t'{in_light, level_stable, b, 1'b1, 1'b0});
    end
    results_due.push_back(result_t'{in_light, level_stable, sum, 1'b1, closes});
  endfunction

  // One tick of the debounce / long-press toggle; queues its results if asked
  function automatic void advance_toggle(input logic lvl, input logic record);
    change_t    chg;
    logic       is_long;
    logic [7:0] vol;
    chg = CHG_NONE;
    // press timer runs while the accepted level is high, stops at its ceiling
    if (level_stable && press_cnt != '1) press_cnt++;
    if (lvl != raw_prev) hold_cnt = '0;
    else if (hold_cnt != '1) hold_cnt++;
    if (hold_cnt > cfg_debounce && lvl != level_stable) begin
      level_stable = lvl;
      if (lvl) begin
        press_cnt = '0;
      end else begin
        is_long = (press_cnt >= cfg_long_press);
        if (!in_light && is_long) begin
          in_light = 1'b1;
          chg = CHG_LIGHT;
        end else if (in_light && !is_long) begin
          in_light = 1'b0;
          chg = CHG_MOTION;
        end
      end
    end
    raw_prev = lvl;
    if (!record) return;
    if (chg == CHG_NONE) begin
      results_due.push_back(result_t'{in_light, level_stable, 8'h00, 1'b0, 1'b1});
    end else begin
      vol = ({3'b000, cfg_volume} > VOLUME_CAP) ? VOLUME_CAP : {3'b000, cfg_volume};
      queue_frame({8'h00, FRAME_HEAD, OP_VOLUME, LEN_VOLUME, vol}, 4, chg == CHG_MOTION);
      if (chg == CHG_LIGHT)
        queue_frame({FRAME_HEAD, OP_TRACK, LEN_TRACK, cfg_track[15:8], cfg_track[7:0]},
                    5, 1'b1);
    end
  endfunction

  // Send one tick request; a typed row supplies its own status result.
  // Valid is only dropped when a gap follows, so back-to-back requests
  // never see a low/high pair in one time step.
  task automatic send_tick(input logic lvl, input logic typed, input logic t_mode,
                           input logic t_stable);
    int gap;
    in_valid     <= 1'b1;
    button_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) begin
      results_due.push_back(result_t'{t_mode, t_stable, 8'h00, 1'b0, 1'b1});
      advance_toggle(lvl, 1'b0);
    end else begin
      advance_toggle(lvl, 1'b1);
    end
    sent_ticks++;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_level(input logic lvl, input int n);
    repeat (n) send_tick(lvl, 1'b0, 1'b0, 1'b0);
  endtask

  // Register writes only once every expected result is out and the block is idle
  task automatic write_reg(input cfg_reg_t sel, input logic [15:0] value);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (sel)
      REG_DEBOUNCE:   cfg_debounce   = value;
      REG_LONG_PRESS: cfg_long_press = value;
      REG_VOLUME:     cfg_volume     = value[4:0];
      REG_TRACK:      cfg_track      = value;
      default: ;
    endcase
  endtask

  // Output side: check each taken result against the oldest expectation,
  // then choose ready for the next cycle (random stalls outside quiet stretches)
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result, frame_byte", frame_byte, 0);
      end else begin
        want = results_due.pop_front();
        if (mode_now !== want.mode)
          report_mismatch("mode_now", mode_now, want.mode);
        if (stable_level !== want.stable)
          report_mismatch("stable_level", stable_level, want.stable);
        if (frame_byte !== want.data)
          report_mismatch("frame_byte", frame_byte, want.data);
        if (byte_valid !== want.carried)
          report_mismatch("byte_valid", byte_valid, want.carried);
        if (last_of_run !== want.last)
          report_mismatch("last_of_run", last_of_run, want.last);
      end
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left = rand_gap();
    end
  end

  initial begin : stimulus
    int          row;
    int          phase;
    int          phase_end;
    int          pick;
    logic [15:0] deb_val;
    logic [15:0] long_val;
    logic [15:0] vol_val;
    logic [15:0] trk_val;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed plan
    for (row = 0; row < PLAN_ROWS; row++) begin
      if (DIRECTED_PLAN[row].kind == ROW_WRITE)
        write_reg(DIRECTED_PLAN[row].sel, DIRECTED_PLAN[row].value);
      else
        send_tick(DIRECTED_PLAN[row].lvl, DIRECTED_PLAN[row].typed,
                  DIRECTED_PLAN[row].mode, DIRECTED_PLAN[row].stable);
    end

    // Random phases: mostly clean presses around the long-press threshold,
    // some bounces shorter than the debounce window, some raw noise
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      deb_val  = 16'($urandom_range(0, 3));
      long_val = 16'($urandom_range(2, 16));
      vol_val  = 16'($urandom);
      trk_val  = 16'($urandom);
      if (phase == 0) begin
        deb_val  = 16'd0;
        long_val = 16'd1;
        vol_val  = vol_val | 16'h001F;
        trk_val  = 16'h0000;
      end else if (phase == 1) begin
        deb_val  = 16'd8;
        long_val = 16'd0;
        vol_val  = vol_val & 16'hFFE0;
        trk_val  = 16'hFFFF;
      end else if ($urandom_range(0, 4) == 0) begin
        deb_val = 16'($urandom_range(5, 8));
      end
      write_reg(REG_DEBOUNCE, deb_val);
      write_reg(REG_LONG_PRESS, long_val);
      write_reg(REG_VOLUME, vol_val);
      write_reg(REG_TRACK, trk_val);

      quiet = ($urandom_range(0, 3) == 0);
      phase_end = sent_ticks + PHASE_TICKS;
      while (sent_ticks < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          hold_level(1'b1, int'(cfg_debounce) + 1 +
                     $urandom_range(1, int'(cfg_long_press) + 4));
          hold_level(1'b0, int'(cfg_debounce) + 2 + $urandom_range(0, 2));
        end else if (pick < 9) begin
          hold_level(1'b1, $urandom_range(1, int'(cfg_debounce) + 1));
          hold_level(1'b0, int'(cfg_debounce) + 2);
        end else begin
          repeat ($urandom_range(1, 6))
            send_tick(1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0);
        end
      end
      quiet = 1'b0;
    end

    // Drain, then give stray results time to show up
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0)
      $display("long_press_mode_toggle_cmd verification clean");
    else
      $display("long_press_mode_toggle_cmd verification failed");
    $finish;
  end

endmodule
